FILE: rtl/fba_pkg.sv
package fba_pkg;

  localparam int AddrWidth    = 32;
  localparam int MaxBlocksDef = 64;
  localparam int SizeW        = 17;
  localparam int CountW       = 7;
  localparam int IdxW         = 7;
  localparam int RIdxW        = 6;
  localparam int OffW         = 22;
  localparam int ProdW        = IdxW + SizeW;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 32;
  localparam int ScanW        = 8;

  localparam logic [SizeW-1:0]     SizeCap       = SizeW'(65536);
  localparam logic [SizeW-1:0]     SizeReset     = SizeW'(64);
  localparam logic [CountW-1:0]    CountReset    = CountW'(64);
  localparam logic [AddrWidth-1:0] BaseReset     = '0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBlockSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBufferBase = 2'd2;

  typedef enum logic [1:0] {
    ActAlloc  = 2'd0,
    ActFree   = 2'd1,
    ActLocate = 2'd2,
    ActFind   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDivide,
    StMult,
    StFinish
  } state_e;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic div_step;
    logic mul_step;
    logic out_load;
  } fba_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
    logic slot_free;
  } fba_stat_t;

endpackage

FILE: rtl/fba_req_if.sv
interface fba_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [fba_pkg::IdxW-1:0]       block_index;
  logic [fba_pkg::AddrWidth-1:0]  address;

  modport source (output valid, action, block_index, address, input ready);
  modport sink   (input valid, action, block_index, address, output ready);
endinterface

FILE: rtl/fba_rsp_if.sv
interface fba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [fba_pkg::RIdxW-1:0]      result_index;
  logic [fba_pkg::OffW-1:0]       byte_offset;
  logic [fba_pkg::AddrWidth-1:0]  block_address;

  modport source (output valid, status, result_index, byte_offset, block_address,
                  input ready);
  modport sink   (input valid, status, result_index, byte_offset, block_address,
                  output ready);
endinterface

FILE: rtl/fba_ctrl.sv
module fba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fba_pkg::action_e  in_action_i,
  output logic              in_ready_o,
  input  fba_pkg::fba_stat_t stat_i,
  output fba_pkg::fba_cmd_t  cmd_o
);
  import fba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          case (in_action_i)
            ActAlloc:  state_d = StScan;
            ActFree:   state_d = StFinish;
            ActLocate: state_d = StMult;
            default:   state_d = StDivide;
          endcase
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = StFinish;
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = StFinish;
      end
      StMult: begin
        cmd_o.mul_step = 1'b1;
        state_d        = StFinish;
      end
      StFinish: begin
        if (stat_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.scan_step, cmd_o.div_step, cmd_o.mul_step, cmd_o.out_load}))
    else $error("more than one datapath command");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.slot_free)
    else $error("result loaded over a pending one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != StIdle))
    else $error("accepted transaction left no work");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> in_ready_o)
    else $error("not ready after result load");

endmodule

FILE: rtl/fba_datapath.sv
module fba_datapath #(
  parameter int MAX_BLOCKS = fba_pkg::MaxBlocksDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fba_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fba_pkg::CfgDataW-1:0]     cfg_data_i,
  input  fba_pkg::action_e                 in_action_i,
  input  logic [fba_pkg::IdxW-1:0]         in_index_i,
  input  logic [fba_pkg::AddrWidth-1:0]    in_address_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_status_o,
  output logic [fba_pkg::RIdxW-1:0]        out_index_o,
  output logic [fba_pkg::OffW-1:0]         out_offset_o,
  output logic [fba_pkg::AddrWidth-1:0]    out_address_o,
  input  fba_pkg::fba_cmd_t                cmd_i,
  output fba_pkg::fba_stat_t               stat_o
);
  import fba_pkg::*;

  localparam int Groups   = (MAX_BLOCKS + ScanW - 1) / ScanW;
  localparam int PadW     = Groups * ScanW;
  localparam int GrpW     = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int LaneW    = $clog2(ScanW);
  localparam int SlotW    = GrpW + LaneW;
  localparam int DivSteps = AddrWidth / 2;
  localparam int StepW    = $clog2(DivSteps);
  localparam int RemW     = SizeW + 1;

  // configuration
  logic [SizeW-1:0]     size_q;
  logic [CountW-1:0]    count_q;
  logic [AddrWidth-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SizeReset;
      count_q <= CountReset;
      base_q  <= BaseReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBlockSize:  size_q  <= cfg_data_i[SizeW-1:0];
        CfgBlockCount: count_q <= cfg_data_i[CountW-1:0];
        CfgBufferBase: base_q  <= cfg_data_i[AddrWidth-1:0];
        default: ;
      endcase
    end
  end

  logic [SizeW-1:0]  asize;
  logic [CountW-1:0] acount;
  assign asize  = (size_q > SizeCap) ? SizeCap : size_q;
  assign acount = (32'(count_q) > MAX_BLOCKS) ? CountW'(MAX_BLOCKS) : count_q;

  // captured item
  action_e           act_q;
  logic [IdxW-1:0]   idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q <= in_action_i;
      idx_q <= in_index_i;
    end
  end

  // used bitmap, padding lanes read as used
  logic [MAX_BLOCKS-1:0] used_q;
  logic [PadW-1:0]       used_pad;

  for (genvar j = 0; j < PadW; j++) begin : g_pad
    if (j < MAX_BLOCKS) begin : g_real
      assign used_pad[j] = used_q[j];
    end else begin : g_fill
      assign used_pad[j] = 1'b1;
    end
  end

  // allocate scan, one group of lanes a cycle
  logic [GrpW-1:0]  grp_q;
  logic             found_q;
  logic [SlotW-1:0] found_idx_q;
  logic [ScanW-1:0] grp_used, grp_free;
  logic [LaneW-1:0] pick;
  logic             hit;

  assign grp_used = used_pad[{grp_q, {LaneW{1'b0}}} +: ScanW];

  always_comb begin
    pick = '0;
    for (int k = 0; k < ScanW; k++) begin
      grp_free[k] = !grp_used[k] && (32'({grp_q, LaneW'(k)}) < 32'(acount));
    end
    for (int k = ScanW - 1; k >= 0; k--) begin
      if (grp_free[k]) pick = LaneW'(k);
    end
  end
  assign hit = |grp_free;

  assign stat_o.scan_last = hit || (32'(grp_q) == Groups - 1) ||
                            ((32'(grp_q) + 1) * ScanW >= 32'(acount));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      grp_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      grp_q <= grp_q + 1'b1;
      if (hit) begin
        found_q     <= 1'b1;
        found_idx_q <= {grp_q, pick};
      end
    end
  end

  // find: restoring division, two quotient bits a cycle
  logic [RemW-1:0]      rem_q;
  logic [AddrWidth-1:0] dq_q;
  logic [StepW-1:0]     step_q;
  logic                 div_ok_q;
  logic [RemW-1:0]      dsr, t1, r1, t2, r2;
  logic                 ge1, ge2;

  assign dsr = RemW'(asize);

  always_comb begin
    t1  = {rem_q[RemW-2:0], dq_q[AddrWidth-1]};
    ge1 = (t1 >= dsr);
    r1  = ge1 ? (t1 - dsr) : t1;
    t2  = {r1[RemW-2:0], dq_q[AddrWidth-2]};
    ge2 = (t2 >= dsr);
    r2  = ge2 ? (t2 - dsr) : t2;
  end

  assign stat_o.div_last = (step_q == StepW'(DivSteps - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q    <= '0;
      dq_q     <= in_address_i - base_q;
      step_q   <= '0;
      div_ok_q <= (asize != '0) && (in_address_i >= base_q);
    end else if (cmd_i.div_step) begin
      rem_q  <= r2;
      dq_q   <= {dq_q[AddrWidth-3:0], ge1, ge2};
      step_q <= step_q + 1'b1;
    end
  end

  // locate product
  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q <= ProdW'(idx_q) * ProdW'(asize);
    end
  end

  // result selection
  logic idx_ok, find_ok;
  assign idx_ok  = (idx_q < acount);
  assign find_ok = div_ok_q && (dq_q < AddrWidth'(acount));

  logic                 res_status;
  logic [RIdxW-1:0]     res_index;
  logic [OffW-1:0]      res_offset;
  logic [AddrWidth-1:0] res_address;

  always_comb begin
    res_status  = 1'b1;
    res_index   = '0;
    res_offset  = '0;
    res_address = '0;
    case (act_q)
      ActAlloc: begin
        res_status = !found_q;
        if (found_q) res_index = RIdxW'(found_idx_q);
      end
      ActFree: res_status = !idx_ok;
      ActLocate: begin
        if (idx_ok) begin
          res_status  = 1'b0;
          res_index   = RIdxW'(idx_q);
          res_offset  = prod_q[OffW-1:0];
          res_address = base_q + AddrWidth'(prod_q);
        end
      end
      default: begin
        if (find_ok) begin
          res_status = 1'b0;
          res_index  = RIdxW'(dq_q);
        end
      end
    endcase
  end

  // bitmap update commits with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.out_load) begin
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        if (act_q == ActAlloc && found_q && 32'(found_idx_q) == j) used_q[j] <= 1'b1;
        if (act_q == ActFree && idx_ok && 32'(idx_q) == j) used_q[j] <= 1'b0;
      end
    end
  end

  // output register
  logic                 out_valid_q;
  logic                 out_status_q;
  logic [RIdxW-1:0]     out_index_q;
  logic [OffW-1:0]      out_offset_q;
  logic [AddrWidth-1:0] out_address_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q  <= res_status;
      out_index_q   <= res_index;
      out_offset_q  <= res_offset;
      out_address_q <= res_address;
    end
  end

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_index_o      = out_index_q;
  assign out_offset_o     = out_offset_q;
  assign out_address_o    = out_address_q;

  a_fail_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_index_q == '0))
    else $error("failed result carries an index");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result register not marked valid");

  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && act_q == ActAlloc && found_q) |=> !$stable(used_q))
    else $error("allocation left the bitmap unchanged");

endmodule

FILE: rtl/fixed_block_allocator.sv
// channel   dir  payload                                               handshake
// req_i     in   action, block_index, address                          valid/ready
// rsp_o     out  status, result_index, byte_offset, block_address      valid/ready
// cfg       in   cfg_index_i, cfg_data_i                               cfg_we_i, no wait
//
// one transaction at a time: free goes straight to the finish state, locate passes the
// multiplier stage, allocate scans the bitmap eight blocks a cycle until a free block or
// the end of the pool, find runs the radix-4 divider, 16 steps for a 32-bit dividend; ready
// again the cycle after the result is loaded into the output register
// reset clears the used bitmap at once and loads the register defaults
// a stalled result holds in the output register while the next request is taken;
// work only stalls when a new result finds the output register still full
module fixed_block_allocator #(
  parameter int MAX_BLOCKS = fba_pkg::MaxBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fba_req_if.sink                       req_i,
  fba_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [fba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fba_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fba_pkg::*;

  // command and status between controller and datapath
  fba_cmd_t  cmd;
  fba_stat_t stat;

  fba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (action_e'(req_i.action)),
    .in_ready_o  (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath holds config, bitmap, scan, divider, multiplier and result register
  fba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_action_i   (action_e'(req_i.action)),
    .in_index_i    (req_i.block_index),
    .in_address_i  (req_i.address),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .out_status_o  (rsp_o.status),
    .out_index_o   (rsp_o.result_index),
    .out_offset_o  (rsp_o.byte_offset),
    .out_address_o (rsp_o.block_address),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

FILE: tb/tb.sv
module tb;
  import fba_pkg::*;

  // index past the last register, the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam int unsigned CycleLimit = 400000;
  localparam int          PhaseCount = 10;
  localparam int          PhaseItems = 75;
  localparam int          LongHold   = 400;
  // slowest request is find (divider), leave margin for the output register
  localparam int          TailCycles = 40;

  // one response of the allocator
  typedef struct packed {
    logic                 status;
    logic [RIdxW-1:0]     rindex;
    logic [OffW-1:0]      offset;
    logic [AddrWidth-1:0] baddr;
  } pool_rsp_t;

  // directed stimulus row: either a register write or a request
  typedef struct packed {
    logic                 reg_row;
    logic [CfgIdxW-1:0]   sel;
    logic [CfgDataW-1:0]  val;
    action_e              act;
    logic [IdxW-1:0]      idx;
    logic [AddrWidth-1:0] addr;
    logic                 typed;
    pool_rsp_t            want;
  } plan_row_t;

  localparam pool_rsp_t RspErr = '{1'b1, 6'd0, 22'd0, 32'd0};
  localparam int        PlanRows = 34;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  fba_req_if req_if ();
  fba_rsp_if rsp_if ();

  fixed_block_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the pool: used bitmap and register copies
  logic [MaxBlocksDef-1:0] used_blocks;
  logic [SizeW-1:0]        pool_size;
  logic [CountW-1:0]       pool_count;
  logic [AddrWidth-1:0]    pool_base;

  pool_rsp_t   pending_rsp[$];
  pool_rsp_t   head_rsp;
  plan_row_t   plan [PlanRows];

  int unsigned cycles;
  int          mismatches;
  int          checked;
  int          refusals;
  int          sent;
  int          settings;
  int          per_action [4];
  int          burst_left;
  bit          hold_go;

  // clock, period 4
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog, ends a hung run
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending_rsp.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // expected response for one request; updates the shadow bitmap
  function automatic pool_rsp_t predict_pool(action_e act, logic [IdxW-1:0] idx,
                                             logic [AddrWidth-1:0] addr);
    pool_rsp_t       r;
    int unsigned     cnt;
    int unsigned     sz;
    longint unsigned quot;
    bit              taken;
    r     = RspErr;
    taken = 1'b0;
    // count above the pool depth and size above the cap saturate
    cnt = (pool_count > MaxBlocksDef) ? MaxBlocksDef : pool_count;
    sz  = (pool_size > SizeCap) ? SizeCap : pool_size;
    case (act)
      ActAlloc: begin
        // lowest free block wins
        for (int i = 0; i < cnt; i++) begin
          if (!taken && !used_blocks[i]) begin
            used_blocks[i] = 1'b1;
            taken          = 1'b1;
            r.status       = 1'b0;
            r.rindex       = i[RIdxW-1:0];
          end
        end
      end
      ActFree: begin
        // out-of-range index is refused, freeing a free block is harmless
        if (idx < cnt) begin
          used_blocks[idx[RIdxW-1:0]] = 1'b0;
          r.status = 1'b0;
        end
      end
      ActLocate: begin
        if (idx < cnt) begin
          r.status = 1'b0;
          r.rindex = idx[RIdxW-1:0];
          r.offset = OffW'(idx * sz);
          r.baddr  = pool_base + AddrWidth'(idx * sz);
        end
      end
      default: begin
        // zero size and an address below the base are refused, no wrap
        if (sz != 0 && addr >= pool_base) begin
          quot = (addr - pool_base) / sz;
          if (quot < cnt) begin
            r.status = 1'b0;
            r.rindex = quot[RIdxW-1:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  // sender burst shaping: a run of back-to-back requests, then a gap
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 24);
    return $urandom_range(1, 8);
  endfunction

  // offer one request, wait for the transaction, then record its expectation
  task automatic send_item(action_e act, logic [IdxW-1:0] idx, logic [AddrWidth-1:0] addr,
                           logic typed, pool_rsp_t want);
    int        gap;
    pool_rsp_t got;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.block_index <= idx;
    req_if.address     <= addr;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    got = predict_pool(act, idx, addr);
    pending_rsp.push_back(typed ? want : got);
    sent++;
    per_action[act]++;
  endtask

  // drop valid and wait until every response is back, block is idle then
  task automatic settle_pool();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // one register write, mirrored into the shadow copy
  task automatic write_reg(logic [CfgIdxW-1:0] sel, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      CfgBlockSize:  pool_size  = val[SizeW-1:0];
      CfgBlockCount: pool_count = val[CountW-1:0];
      CfgBufferBase: pool_base  = val[AddrWidth-1:0];
      default: ;
    endcase
    settings++;
  endtask

  // receiver: long hold-off on request, otherwise stall patterns in segments
  initial begin
    int seg_left;
    int rx_mode;
    int hold_left;
    rsp_if.ready = 1'b0;
    seg_left     = 0;
    rx_mode      = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (rx_mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  // response checker, oldest expectation first
  always @(posedge clk_i) begin
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      checked++;
      if (rsp_if.status === 1'b1) refusals++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        head_rsp = pending_rsp.pop_front();
        if (rsp_if.status !== head_rsp.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_if.status,
                                    head_rsp.status));
        if (rsp_if.result_index !== head_rsp.rindex)
          report_mismatch($sformatf("result_index got %0d want %0d", rsp_if.result_index,
                                    head_rsp.rindex));
        if (rsp_if.byte_offset !== head_rsp.offset)
          report_mismatch($sformatf("byte_offset got %h want %h", rsp_if.byte_offset,
                                    head_rsp.offset));
        if (rsp_if.block_address !== head_rsp.baddr)
          report_mismatch($sformatf("block_address got %h want %h", rsp_if.block_address,
                                    head_rsp.baddr));
      end
    end
  end

  initial begin
    int unsigned          cnt_eff;
    int unsigned          sz_eff;
    int unsigned          span;
    int                   alloc_pct;
    int                   roll;
    action_e              act;
    logic [IdxW-1:0]      idx;
    logic [AddrWidth-1:0] addr;
    logic [SizeW-1:0]     new_size;
    logic [CountW-1:0]    new_count;
    logic [AddrWidth-1:0] new_base;

    // everything known from time zero
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CfgBlockSize;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.action      = ActAlloc;
    req_if.block_index = '0;
    req_if.address     = '0;
    used_blocks        = '0;
    pool_size          = SizeReset;
    pool_count         = CountReset;
    pool_base          = BaseReset;
    mismatches = 0;
    checked    = 0;
    refusals   = 0;
    sent       = 0;
    settings   = 0;
    burst_left = 0;
    hold_go    = 1'b0;
    per_action = '{0, 0, 0, 0};

    // directed part: reset defaults, then each corner of the register space
    plan = '{
      // defaults: size 64, count 64, base 0
      '{1'b0, CfgUnused, 32'h0, ActAlloc,  7'd0,   32'h0, 1'b1, '{1'b0, 6'd0, 22'd0, 32'd0}},
      '{1'b0, CfgUnused, 32'h0, ActAlloc,  7'd0,   32'h0, 1'b1, '{1'b0, 6'd1, 22'd0, 32'd0}},
      '{1'b0, CfgUnused, 32'h0, ActFree,   7'd1,   32'h0, 1'b1, '{1'b0, 6'd0, 22'd0, 32'd0}},
      // free out of range
      '{1'b0, CfgUnused, 32'h0, ActFree,   7'd127, 32'h0, 1'b1, RspErr},
      // free of a block that is already free
      '{1'b0, CfgUnused, 32'h0, ActFree,   7'd40,  32'h0, 1'b1, '{1'b0, 6'd0, 22'd0, 32'd0}},
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd63,  32'h0, 1'b1,
        '{1'b0, 6'd63, 22'd4032, 32'd4032}},
      // locate out of range
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd64,  32'h0, 1'b1, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'd4095, 1'b1,
        '{1'b0, 6'd63, 22'd0, 32'd0}},
      // find beyond the pool
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'd4096, 1'b1, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd127, 32'hFFFF_FFFF, 1'b1, RspErr},
      '{1'b1, CfgBufferBase, 32'h1000_0000, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      // address just below the base
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'h0FFF_FFFF, 1'b1, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'h1000_0040, 1'b1,
        '{1'b0, 6'd1, 22'd0, 32'd0}},
      // two-block pool, block 0 taken: one allocate, then pool full
      '{1'b1, CfgBlockCount, 32'd2, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActAlloc,  7'd0,   32'h0, 1'b1, '{1'b0, 6'd1, 22'd0, 32'd0}},
      '{1'b0, CfgUnused, 32'h0, ActAlloc,  7'd0,   32'h0, 1'b1, RspErr},
      // count past the pool depth saturates
      '{1'b1, CfgBlockCount, 32'd127, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd63,  32'h0, 1'b1,
        '{1'b0, 6'd63, 22'd4032, 32'h1000_0FC0}},
      '{1'b0, CfgUnused, 32'h0, ActFree,   7'd64,  32'h0, 1'b1, RspErr},
      // zero block size
      '{1'b1, CfgBlockSize, 32'd0, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd5,   32'h0, 1'b1,
        '{1'b0, 6'd5, 22'd0, 32'h1000_0000}},
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'h1000_0000, 1'b1, RspErr},
      // size past the cap acts as 65536
      '{1'b1, CfgBlockSize, 32'h1_FFFF, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd63,  32'h0, 1'b1,
        '{1'b0, 6'd63, 22'h3F_0000, 32'h103F_0000}},
      // top base: block address wraps
      '{1'b1, CfgBufferBase, 32'hFFFF_FFFF, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd1,   32'h0, 1'b1,
        '{1'b0, 6'd1, 22'h1_0000, 32'h0000_FFFF}},
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'hFFFF_FFFF, 1'b1,
        '{1'b0, 6'd0, 22'd0, 32'd0}},
      // write to the unused index changes nothing
      '{1'b1, CfgUnused, 32'h0000_DEAD, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActLocate, 7'd2,   32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActAlloc,  7'd0,   32'h0, 1'b0, RspErr},
      // empty pool
      '{1'b1, CfgBlockSize, 32'd1, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b1, CfgBlockCount, 32'd0, ActAlloc, 7'd0, 32'h0, 1'b0, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActAlloc,  7'd0,   32'h0, 1'b1, RspErr},
      '{1'b0, CfgUnused, 32'h0, ActFind,   7'd0,   32'hFFFF_FFFF, 1'b1, RspErr}
    };

    // reset once
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].reg_row) begin
        settle_pool();
        write_reg(plan[k].sel, plan[k].val);
      end else begin
        send_item(plan[k].act, plan[k].idx, plan[k].addr, plan[k].typed, plan[k].want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PhaseCount; p++) begin
      settle_pool();
      if (p == 0) begin
        // full-depth pool, allocate-heavy so the bitmap fills up
        new_size  = SizeReset;
        new_count = CountReset;
        alloc_pct = 90;
      end else begin
        case ($urandom_range(0, 7))
          0:       new_size = SizeW'(1);
          1:       new_size = SizeReset;
          2:       new_size = SizeCap;
          3:       new_size = '0;
          4:       new_size = '1;
          5:       new_size = SizeW'($urandom_range(1, 65536));
          6:       new_size = SizeW'($urandom_range(1, 256));
          default: new_size = SizeW'(1) << $urandom_range(0, 16);
        endcase
        case ($urandom_range(0, 5))
          0:       new_count = '0;
          1:       new_count = CountW'(1);
          2:       new_count = CountReset;
          3:       new_count = '1;
          4:       new_count = CountW'($urandom_range(1, 16));
          default: new_count = CountW'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 2))
          0:       alloc_pct = 10;
          1:       alloc_pct = 40;
          default: alloc_pct = 70;
        endcase
      end
      case ($urandom_range(0, 3))
        0:       new_base = '0;
        1:       new_base = '1;
        2:       new_base = $urandom;
        default: new_base = $urandom & 32'hFFFF_0000;
      endcase
      write_reg(CfgBlockSize, CfgDataW'(new_size));
      write_reg(CfgBlockCount, CfgDataW'(new_count));
      write_reg(CfgBufferBase, new_base);
      if (p == 1) hold_go = 1'b1;

      cnt_eff = (pool_count > MaxBlocksDef) ? MaxBlocksDef : pool_count;
      sz_eff  = (pool_size > SizeCap) ? SizeCap : pool_size;
      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          act = ActAlloc;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: act = ActFree;
            4, 5, 6:    act = ActLocate;
            default:    act = ActFind;
          endcase
        end
        // mostly in-range indexes, the rest anywhere in the field
        if (cnt_eff > 0 && $urandom_range(0, 4) != 0)
          idx = IdxW'($urandom_range(0, cnt_eff - 1));
        else
          idx = IdxW'($urandom_range(0, 127));
        addr = $urandom;
        // finds mostly land in or just past the pool
        if (act == ActFind && sz_eff != 0 && $urandom_range(0, 9) < 6) begin
          span = cnt_eff * sz_eff + sz_eff;
          addr = pool_base + AddrWidth'($urandom_range(0, span - 1));
        end
        send_item(act, idx, addr, 1'b0, RspErr);
      end
    end

    settle_pool();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d allocate, %0d free, %0d locate, %0d find",
             sent, per_action[ActAlloc], per_action[ActFree], per_action[ActLocate],
             per_action[ActFind]);
    $display("%0d register writes, %0d responses checked, %0d refused, %0d mismatches",
             settings, checked, refusals, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
